>>> hdl/dbsc_pkg.sv
// shared constants and types of the de bruijn sequence checker
// no dependencies; imported by dbsc_front and de_bruijn_sequence_checker_unit
`default_nettype none

package dbsc_pkg;

    localparam int MAX_ORDER = 16;
    localparam int ORDER_W   = 5;
    localparam int CNT_W     = MAX_ORDER + 1;
    localparam int MAP_AW    = MAX_ORDER;
    localparam int EPOCH_W   = 8;
    localparam int PADDR_W   = 3;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    // register index, taken from paddr above the byte offset
    localparam logic REG_ORDER = 1'b0;

    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(3);

    // lookup request of one word, from the front stage to the tag ram stage
    typedef struct packed {
        logic [MAP_AW-1:0] addr;
        logic              look;
        logic              len_ok;
        logic              last;
    } front_t;

endpackage

`default_nettype wire

>>> hdl/dbsc_front.sv
// front stage: shift window, saturating bit count, window address and length test
// depends on dbsc_pkg
`default_nettype none

module dbsc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic                           bit_in,
    input  wire logic                           last_bit,
    input  wire logic [dbsc_pkg::ORDER_W-1:0]   order,
    output dbsc_pkg::front_t                    info
);
    import dbsc_pkg::*;

    logic [MAX_ORDER-1:0] window_reg;
    logic [MAX_ORDER-1:0] window_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     mask;
    logic [CNT_W-1:0]     expect_len;
    logic                 order_ok;

    always_comb
    begin
        window_next = {window_reg[MAX_ORDER-2:0], bit_in};
        count_next  = (count_reg == CNT_MAX) ? count_reg : count_reg + CNT_W'(1);
        order_ok    = (order != '0) && (order <= ORDER_W'(MAX_ORDER));
        mask        = (CNT_W'(1) << order) - CNT_W'(1);
        expect_len  = (CNT_W'(1) << order) + CNT_W'(order) - CNT_W'(1);

        info.addr   = window_next & mask[MAP_AW-1:0];
        info.look   = order_ok && (count_next >= CNT_W'(order));
        info.len_ok = order_ok && (count_next == expect_len);
        info.last   = last_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_bit)
            begin
                window_reg <= '0;
                count_reg  <= '0;
            end
            else
            begin
                window_reg <= window_next;
                count_reg  <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/de_bruijn_sequence_checker_unit.sv
// top level of the de bruijn sequence checker: apb register, tag ram, result register
// depends on dbsc_pkg and dbsc_front
//
//   channel  dir  handshake              payload
//   s_       in   s_tvalid / s_tready    s_tdata[0] bit_in, s_tlast last_bit
//   m_       out  m_tvalid / m_tready    m_tdata[0] is_debruijn, one word per string
//   apb      in   psel / penable, pready register order at byte address 0
//
// one input word per cycle while s_tready is high; the tag ram takes one
// read-modify-write per word, read in the accept cycle and written from stage 1,
// with a bypass for back-to-back hits on the same window. the ram holds an epoch
// tag per window value, so no clearing is needed between strings. a clearing pass
// runs after reset and after every 255 strings; s_tready is low meanwhile. a
// stall on m_ only holds the input when a finished result has nowhere to go.
`default_nettype none

module de_bruijn_sequence_checker_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // apb
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dbsc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [0] bit_in, [7:1] zero
    input  wire logic                          s_tlast,   // last_bit
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [7:0]                    m_tdata    // [0] is_debruijn, [7:1] zero
);
    import dbsc_pkg::*;

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    logic                 state_reg;
    logic [MAP_AW-1:0]    clr_cnt_reg;
    logic [ORDER_W-1:0]   order_reg;
    logic [EPOCH_W-1:0]   epoch_reg;

    logic [EPOCH_W-1:0]   tag_mem [2**MAP_AW];
    logic [EPOCH_W-1:0]   rd_data_reg;

    logic                 s1_valid_reg;
    front_t               s1_reg;
    logic [EPOCH_W-1:0]   s1_epoch_reg;
    logic                 s1_fwd_reg;
    logic                 repeat_reg;

    logic                 out_valid_reg;
    logic                 out_bit_reg;

    front_t               f;
    logic                 accept;
    logic                 s1_move;
    logic                 hit;
    logic                 fwd;
    logic                 clr_step;
    logic                 wr_en;
    logic [MAP_AW-1:0]    wr_addr;
    logic [EPOCH_W-1:0]   wr_data;

    // apb
    assign pready = 1'b1;
    assign prdata = {{(32-ORDER_W){1'b0}}, order_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORDER_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_ORDER))
            order_reg <= pwdata[ORDER_W-1:0];
    end

    dbsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .bit_in   (s_tdata[0]),
        .last_bit (s_tlast),
        .order    (order_reg),
        .info     (f)
    );

    // a last word in stage 1 needs the result register free
    assign s1_move  = s1_valid_reg && (!s1_reg.last || !out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_RUN) && (!s1_valid_reg || s1_move);
    assign accept   = s_tvalid && s_tready;

    // stage 1 writes the same entry at this edge, so its tag is not yet in the ram
    assign fwd = s1_valid_reg && s1_reg.look && !s1_reg.last && (s1_reg.addr == f.addr);
    assign hit = s1_reg.look && (s1_fwd_reg || (rd_data_reg == s1_epoch_reg));

    // clearing waits for the last stage 1 write to land
    assign clr_step = (state_reg == ST_CLEAR) && !s1_valid_reg;
    assign wr_en    = (s1_move && s1_reg.look) || clr_step;
    assign wr_addr  = clr_step ? clr_cnt_reg : s1_reg.addr;
    assign wr_data  = clr_step ? '0 : s1_epoch_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tag_mem[wr_addr] <= wr_data;
        if (accept && f.look)
            rd_data_reg <= tag_mem[f.addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= f;
            s1_epoch_reg <= epoch_reg;
            s1_fwd_reg   <= fwd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            epoch_reg     <= EPOCH_ONE;
            s1_valid_reg  <= 1'b0;
            repeat_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_bit_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_step)
                    begin
                        clr_cnt_reg <= clr_cnt_reg + MAP_AW'(1);
                        if (clr_cnt_reg == {MAP_AW{1'b1}})
                            state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (accept && s_tlast)
                    begin
                        if (epoch_reg == EPOCH_MAX)
                        begin
                            epoch_reg   <= EPOCH_ONE;
                            clr_cnt_reg <= '0;
                            state_reg   <= ST_CLEAR;
                        end
                        else
                            epoch_reg <= epoch_reg + EPOCH_W'(1);
                    end
                end
                default:
                    state_reg <= ST_CLEAR;
            endcase

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
            begin
                if (s1_reg.last)
                    repeat_reg <= 1'b0;
                else if (hit)
                    repeat_reg <= 1'b1;
            end

            if (s1_move && s1_reg.last)
            begin
                out_valid_reg <= 1'b1;
                out_bit_reg   <= s1_reg.len_ok && !(repeat_reg || hit);
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_bit_reg};

    // no word enters while the tag ram is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("word accepted during tag clearing");

    // epoch zero marks a cleared entry and is never current
    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch reached the cleared value");

    // a finishing string always lands in the result register
    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_reg.last) |=> (out_valid_reg && !s1_valid_reg) || out_valid_reg)
        else $error("result of a string was lost");

    // bypass only between neighboring words of one string
    a_fwd_same_string: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fwd) |-> (s1_move && !s1_reg.last && f.look))
        else $error("tag bypass across a string boundary");

    // clearing never overlaps a stage 1 write
    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        clr_step |-> !(s1_move && s1_reg.look))
        else $error("tag clear collides with a lookup write");

endmodule

`default_nettype wire
